// ----- rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants for the bounded deque: command codes, status codes,
// field widths and default sizes.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 64;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

// ----- rtl/bounded_deque_with_reverse_top.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_reverse_top
// Bounded double-ended queue held in a ring memory, with constant-time
// reverse by a direction flag.
// ----------------------------------------------------------------------------
// For each command item, in the accept cycle the pointers and count are
// updated, a pushed value is written to the slot memory, and the new front
// and back slots are read into registered read ports; the result reaches
// the output register in the next cycle. A new item is accepted once no
// read is in flight and the output register is free or being taken, so the
// block takes no new item until the last one's result is in the output
// register. The slot memory is not cleared after reset; only occupied slots
// are ever reported, and an empty deque reports zero for both ends.
// ----------------------------------------------------------------------------
module bounded_deque_with_reverse_top #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEFAULT,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int IN_N  = bdq_pkg::CMD_W + DATA_WIDTH,
    localparam int IN_W  = ((IN_N + 7) / 8) * 8,
    localparam int OUT_N = 2 * DATA_WIDTH + CW + 1 + bdq_pkg::STATUS_W,
    localparam int OUT_W = ((OUT_N + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // cmd, data_value
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // front_value, back_value, entry_count,
                                        // is_empty, status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = AW + 1;
    localparam int CMD_W = bdq_pkg::CMD_W;
    localparam int ST_W  = bdq_pkg::STATUS_W;

    localparam int O_BACK  = DATA_WIDTH;
    localparam int O_COUNT = 2 * DATA_WIDTH;
    localparam int O_EMPTY = O_COUNT + CW;
    localparam int O_STAT  = O_EMPTY + 1;

    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

    logic [DATA_WIDTH-1:0] slot_mem [DEPTH];

    logic [AW-1:0]         head_reg,  head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  rev_reg,   rev_next;
    logic                  pend_reg;
    logic                  m_tvalid_reg;

    logic [DATA_WIDTH-1:0] rd_lo_reg, rd_hi_reg;
    logic                  fwd_lo_reg, fwd_hi_reg;
    logic [DATA_WIDTH-1:0] wdata_reg;
    logic [ST_W-1:0]       status_reg, status_next;

    logic [DATA_WIDTH-1:0] front_reg, back_reg;
    logic [CW-1:0]         ocount_reg;
    logic                  oempty_reg;
    logic [ST_W-1:0]       ostatus_reg;

    logic [CMD_W-1:0]      cmd;
    logic [DATA_WIDTH-1:0] din;
    logic                  accept;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         head_inc, head_dec, tail_slot, last_next;
    logic [SW-1:0]         tail_sum, last_sum;
    logic                  is_full, is_emp;
    logic [DATA_WIDTH-1:0] lo_val, hi_val;

    assign cmd    = s_tdata[CMD_W-1:0];
    assign din    = s_tdata[CMD_W +: DATA_WIDTH];
    assign s_tready = !pend_reg && (!m_tvalid_reg || m_tready);
    assign accept = s_tvalid && s_tready;

    assign is_full = (count_reg == DEPTH_C);
    assign is_emp  = (count_reg == '0);

    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - AW'(1);

    always_comb
    begin
        tail_sum  = SW'(head_reg) + SW'(count_reg);
        tail_slot = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
    end

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        status_next = bdq_pkg::STATUS_DONE;
        wr_en       = 1'b0;
        wr_addr     = tail_slot;
        unique case (cmd)
            bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = bdq_pkg::STATUS_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    if ((cmd == bdq_pkg::CMD_PUSH_FRONT) != rev_reg)
                    begin
                        head_next = head_dec;
                        wr_addr   = head_dec;
                    end
                end
            end
            bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK:
            begin
                if (is_emp)
                begin
                    status_next = bdq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    if ((cmd == bdq_pkg::CMD_POP_FRONT) != rev_reg)
                    begin
                        head_next = head_inc;
                    end
                end
            end
            bdq_pkg::CMD_REVERSE:
            begin
                if (is_emp)
                begin
                    status_next = bdq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    rev_next = !rev_reg;
                end
            end
            default:
            begin
                status_next = bdq_pkg::STATUS_DONE;
            end
        endcase
    end

    always_comb
    begin
        last_sum  = SW'(head_next) + SW'(count_next) - SW'(1);
        if (count_next == '0)
        begin
            last_next = head_next;
        end
        else if (last_sum >= DEPTH_S)
        begin
            last_next = AW'(last_sum - DEPTH_S);
        end
        else
        begin
            last_next = AW'(last_sum);
        end
    end

    // slot memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            slot_mem[wr_addr] <= din;
        end
        if (accept)
        begin
            rd_lo_reg <= slot_mem[head_next];
            rd_hi_reg <= slot_mem[last_next];
        end
    end

    // forward a value written in the same cycle as its read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_lo_reg <= wr_en && (wr_addr == head_next);
            fwd_hi_reg <= wr_en && (wr_addr == last_next);
            wdata_reg  <= din;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            rev_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= accept;
            if (accept)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
                rev_reg   <= rev_next;
            end
            if (pend_reg)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign lo_val = fwd_lo_reg ? wdata_reg : rd_lo_reg;
    assign hi_val = fwd_hi_reg ? wdata_reg : rd_hi_reg;

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            if (is_emp)
            begin
                front_reg <= '0;
                back_reg  <= '0;
            end
            else
            begin
                front_reg <= rev_reg ? hi_val : lo_val;
                back_reg  <= rev_reg ? lo_val : hi_val;
            end
            ocount_reg  <= count_reg;
            oempty_reg  <= is_emp;
            ostatus_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        m_tdata                         = '0;
        m_tdata[DATA_WIDTH-1:0]         = front_reg;
        m_tdata[O_BACK +: DATA_WIDTH]   = back_reg;
        m_tdata[O_COUNT +: CW]          = ocount_reg;
        m_tdata[O_EMPTY]                = oempty_reg;
        m_tdata[O_STAT +: ST_W]         = ostatus_reg;
    end

endmodule

// ----- tb/tb_bounded_deque_with_reverse_top.sv -----
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_reverse_top
// Self-checking bench for the bounded deque. A short command table covers
// empty and full refusals, reverse, and the spare codes. A long random run
// then tilts between filling and draining so the ring keeps reaching both
// ends. Every result is compared field by field against fixed table values
// or a bench deque model, with random stalls on both stream ports.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_reverse_top;

    localparam int CMD_W       = bdq_pkg::CMD_W;
    localparam int STATUS_W    = bdq_pkg::STATUS_W;
    localparam int DEPTH       = bdq_pkg::DEPTH_DEFAULT;
    localparam int DW          = bdq_pkg::DATA_WIDTH_DEFAULT;
    localparam int CW          = $clog2(DEPTH + 1);
    localparam int IN_W        = ((CMD_W + DW + 7) / 8) * 8;
    localparam int OUT_W       = ((2 * DW + CW + 1 + STATUS_W + 7) / 8) * 8;
    localparam int BULK_ITEMS  = 1820;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int ROWS        = 14;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam logic [DW-1:0] ONES = '1;
    localparam logic [DW-1:0] BASE = 64'h0123_4567_89ab_cde0;

    typedef struct packed {
        logic [DW-1:0]       front;
        logic [DW-1:0]       back;
        logic [CW-1:0]       count;
        logic                empty;
        logic [STATUS_W-1:0] status;
    } deque_result_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [DW-1:0]    val;
        logic [4:0]       rep;
        logic             typed;
        deque_result_t    want;
    } stim_row_t;

    typedef enum {TILT_FILL, TILT_DRAIN, TILT_MIX} tilt_t;

    logic             clk;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    deque_result_t expected_q [$];
    int            mismatches  = 0;
    int            cycle_count = 0;
    bit            bulk_phase  = 1'b0;

    // bench copy of the deque
    logic [DW-1:0] ring [DEPTH];
    int            head    = 0;
    int            count   = 0;
    bit            flipped = 1'b0;

    bounded_deque_with_reverse_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic deque_result_t deque_apply(logic [CMD_W-1:0] op, logic [DW-1:0] v);
        deque_result_t r;
        bit            low_end;
        int            last;
        r = '0;
        r.status = bdq_pkg::STATUS_DONE;
        case (op)
            bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK:
                if (count == DEPTH)
                    r.status = bdq_pkg::STATUS_FULL;
                else
                begin
                    low_end = (op == bdq_pkg::CMD_PUSH_FRONT) ^ flipped;
                    if (low_end)
                    begin
                        head = (head + DEPTH - 1) % DEPTH;
                        ring[head] = v;
                    end
                    else
                        ring[(head + count) % DEPTH] = v;
                    count++;
                end
            bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK:
                if (count == 0)
                    r.status = bdq_pkg::STATUS_EMPTY;
                else
                begin
                    low_end = (op == bdq_pkg::CMD_POP_FRONT) ^ flipped;
                    if (low_end)
                        head = (head + 1) % DEPTH;
                    count--;
                end
            bdq_pkg::CMD_REVERSE:
                if (count == 0)
                    r.status = bdq_pkg::STATUS_EMPTY;
                else
                    flipped = !flipped;
            default: ;
        endcase
        if (count != 0)
        begin
            last = (head + count - 1) % DEPTH;
            r.front = flipped ? ring[last] : ring[head];
            r.back  = flipped ? ring[head] : ring[last];
        end
        r.count = CW'(count);
        r.empty = (count == 0);
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd(tilt_t tilt);
        int r;
        int push_pct;
        r = $urandom_range(0, 99);
        if (r < 3)
            return CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        if (r < 13)
            return bdq_pkg::CMD_REVERSE;
        push_pct = (tilt == TILT_FILL) ? 80 : (tilt == TILT_DRAIN) ? 20 : 50;
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? bdq_pkg::CMD_PUSH_BACK : bdq_pkg::CMD_PUSH_FRONT;
        return $urandom_range(0, 1) ? bdq_pkg::CMD_POP_BACK : bdq_pkg::CMD_POP_FRONT;
    endfunction

    function automatic logic [DW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ONES;
            2: return DW'(1) << $urandom_range(0, DW - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_item(logic [CMD_W-1:0] op, logic [DW-1:0] v, logic typed,
                             deque_result_t want);
        deque_result_t got;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({v, op});
        do
            @(posedge clk);
        while (!s_tready);
        got = deque_apply(op, v);
        expected_q.push_back(typed ? want : got);
    endtask

    task automatic idle_after(bit quiet, bit drain);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0 || drain)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            if (drain)
                do
                    @(posedge clk);
                while (expected_q.size() != 0);
        end
    endtask

    task automatic check_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        deque_result_t got;
        deque_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.front  = m_tdata[DW-1:0];
            got.back   = m_tdata[2*DW-1:DW];
            got.count  = m_tdata[2*DW +: CW];
            got.empty  = m_tdata[2*DW + CW];
            got.status = m_tdata[2*DW + CW + 1 +: STATUS_W];
            if (expected_q.size() == 0)
            begin
                $error("result with no item outstanding: %0h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("front_value", want.front, got.front);
                check_field("back_value", want.back, got.back);
                check_field("entry_count", DW'(want.count), DW'(got.count));
                check_field("is_empty", DW'(want.empty), DW'(got.empty));
                check_field("status", DW'(want.status), DW'(got.status));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("bounded_deque_with_reverse_top verification failed");
            $finish;
        end
    end

    // output side: random stalls, one long hold-off once bulk traffic starts
    initial
    begin
        int len;
        int stall;
        bit quiet;
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (bulk_phase && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            quiet = ($urandom_range(0, 4) == 0);
            len   = $urandom_range(8, 60);
            repeat (len)
            begin
                stall = quiet ? 0 : idle_len();
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        stim_row_t script [ROWS];
        tilt_t     tilt;
        bit        quiet;
        int        len;
        int        sent;
        bit        drained;

        script = '{
            '{bdq_pkg::CMD_POP_FRONT, '0, 5'd1, 1'b1,
              '{'0, '0, 5'd0, 1'b1, bdq_pkg::STATUS_EMPTY}},
            '{bdq_pkg::CMD_POP_BACK, ONES, 5'd1, 1'b1,
              '{'0, '0, 5'd0, 1'b1, bdq_pkg::STATUS_EMPTY}},
            '{bdq_pkg::CMD_REVERSE, '0, 5'd1, 1'b1,
              '{'0, '0, 5'd0, 1'b1, bdq_pkg::STATUS_EMPTY}},
            '{CMD_SPARE_HI, ONES, 5'd1, 1'b1,
              '{'0, '0, 5'd0, 1'b1, bdq_pkg::STATUS_DONE}},
            '{bdq_pkg::CMD_PUSH_BACK, ONES, 5'd1, 1'b1,
              '{ONES, ONES, 5'd1, 1'b0, bdq_pkg::STATUS_DONE}},
            '{bdq_pkg::CMD_REVERSE, '0, 5'd1, 1'b1,
              '{ONES, ONES, 5'd1, 1'b0, bdq_pkg::STATUS_DONE}},
            '{bdq_pkg::CMD_POP_FRONT, '0, 5'd1, 1'b1,
              '{'0, '0, 5'd0, 1'b1, bdq_pkg::STATUS_DONE}},
            '{bdq_pkg::CMD_PUSH_FRONT, BASE, 5'd16, 1'b0, '0},
            '{bdq_pkg::CMD_PUSH_BACK, '0, 5'd1, 1'b1,
              '{BASE + 15, BASE, 5'd16, 1'b0, bdq_pkg::STATUS_FULL}},
            '{bdq_pkg::CMD_PUSH_FRONT, ONES, 5'd1, 1'b1,
              '{BASE + 15, BASE, 5'd16, 1'b0, bdq_pkg::STATUS_FULL}},
            '{bdq_pkg::CMD_REVERSE, '0, 5'd1, 1'b0, '0},
            '{bdq_pkg::CMD_POP_BACK, '0, 5'd1, 1'b0, '0},
            '{CMD_SPARE_LO, ONES, 5'd1, 1'b0, '0},
            '{bdq_pkg::CMD_PUSH_BACK, 64'h8000_0000_0000_0001, 5'd1, 1'b0, '0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < ROWS; i++)
            for (int k = 0; k < script[i].rep; k++)
            begin
                send_item(script[i].cmd, script[i].val + DW'(k), script[i].typed,
                          script[i].want);
                idle_after(1'b0, 1'b0);
            end

        bulk_phase = 1'b1;
        sent       = 0;
        drained    = 1'b0;
        while (sent < BULK_ITEMS)
        begin
            tilt  = tilt_t'($urandom_range(0, 2));
            quiet = ($urandom_range(0, 4) == 0);
            len   = $urandom_range(8, 60);
            repeat (len)
            begin
                send_item(pick_cmd(tilt), pick_value(), 1'b0, '0);
                sent++;
                // hold input once mid-run until every result is back
                idle_after(quiet, !drained && sent >= BULK_ITEMS / 2);
                if (sent >= BULK_ITEMS / 2)
                    drained = 1'b1;
            end
        end

        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("bounded_deque_with_reverse_top verification clean");
        else
            $display("bounded_deque_with_reverse_top verification failed");
        $finish;
    end

endmodule
